@@ sv/xesp_pkg.sv @@
// ----------------------------------------------------------------------------
// xesp_pkg: shared types and constants of the XMI event stream parser
// Parser phases, event kinds, the job record handed from front to back,
// and the status byte decode helpers.
// ----------------------------------------------------------------------------
package xesp_pkg;

  // Special bytes of the event stream
  localparam logic [7:0] ST_META       = 8'hFF;
  localparam logic [7:0] ST_SYSEX      = 8'hF0;
  localparam logic [7:0] ST_ESCAPE     = 8'hF7;
  localparam logic [7:0] META_END      = 8'h2F;
  localparam logic [7:0] INTERVAL_MORE = 8'h7F;
  localparam logic [3:0] HI_NOTE_ON    = 4'h9;
  localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
  localparam logic [3:0] HI_POLY       = 4'hA;
  localparam logic [3:0] HI_CONTROL    = 4'hB;
  localparam logic [3:0] HI_PROGRAM    = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESS = 4'hD;
  localparam logic [3:0] HI_PITCH      = 4'hE;

  localparam int          VLQ_BITS      = 28;
  localparam logic [2:0]  VLQ_MAX_BYTES = 3'd4;

  // Parser phase
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_STATUS_DUE,
    PH_META_TYPE,
    PH_META_LEN,
    PH_SYSEX_LEN,
    PH_NOTE_KEY,
    PH_NOTE_VEL,
    PH_NOTE_DUR,
    PH_DATA1,
    PH_DATA2,
    PH_SKIP,
    PH_HALT
  } phase_t;

  // Result kinds, as they appear on the output
  typedef enum logic [2:0] {
    EV_NOTE_ON,
    EV_NOTE_OFF,
    EV_POLY_PRESS,
    EV_CONTROL,
    EV_PROGRAM,
    EV_CHAN_PRESS,
    EV_PITCH_BEND,
    EV_END_TRACK
  } event_kind_t;

  // One decoded byte's worth of results; pair marks a note-on/note-off pair
  typedef struct packed {
    logic                pair;
    event_kind_t         kind;
    logic [3:0]          channel;
    logic [7:0]          first;
    logic [7:0]          second;
    logic [VLQ_BITS-1:0] dur;
  } job_t;

  // Phase entered on a status byte
  function automatic phase_t status_phase(input logic [7:0] b);
    phase_t ph;
    if (b == ST_META) begin
      ph = PH_META_TYPE;
    end else if (b == ST_SYSEX || b == ST_ESCAPE) begin
      ph = PH_SYSEX_LEN;
    end else if (b[7:4] == HI_NOTE_ON) begin
      ph = PH_NOTE_KEY;
    end else if (b[7:4] inside {HI_NOTE_OFF, [HI_POLY:HI_PITCH]}) begin
      ph = PH_DATA1;
    end else begin
      ph = PH_HALT;
    end
    return ph;
  endfunction

  // Event kind of a channel message from the status high nibble
  function automatic event_kind_t kind_of(input logic [3:0] hi);
    event_kind_t k;
    case (hi)
      HI_NOTE_OFF:   k = EV_NOTE_OFF;
      HI_POLY:       k = EV_POLY_PRESS;
      HI_CONTROL:    k = EV_CONTROL;
      HI_PROGRAM:    k = EV_PROGRAM;
      HI_CHAN_PRESS: k = EV_CHAN_PRESS;
      default:       k = EV_PITCH_BEND;
    endcase
    return k;
  endfunction

endpackage

@@ sv/xesp_if.sv @@
// ----------------------------------------------------------------------------
// xesp_if: channel interfaces of the XMI event stream parser
// Byte input channel and decoded event output channel, valid/ready.
// ----------------------------------------------------------------------------
interface xesp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       final_byte;

  modport source (output valid, output byte_value, output final_byte, input ready);
  modport sink   (input valid, input byte_value, input final_byte, output ready);
endinterface

interface xesp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [3:0]  channel_number;
  logic [7:0]  first_data;
  logic [7:0]  second_data;
  logic [31:0] event_tick;
  logic        last_of_run;

  modport source (output valid, output event_kind, output channel_number,
                  output first_data, output second_data, output event_tick,
                  output last_of_run, input ready);
  modport sink   (input valid, input event_kind, input channel_number,
                  input first_data, input second_data, input event_tick,
                  input last_of_run, output ready);
endinterface

@@ sv/xmi_event_stream_parser.sv @@
// ----------------------------------------------------------------------------
// xmi_event_stream_parser: XMI event chunk parser
// Decodes event chunk bytes into MIDI channel events and end-of-track marks
// with absolute ticks.
//
//   channel  dir  payload                                   handshake
//   in_ch    in   byte_value[7:0], final_byte               valid/ready
//   out_ch   out  event_kind, channel_number, first_data,   valid/ready
//                 second_data, event_tick[31:0], last_of_run
//
// One byte per cycle is accepted while the job queue has room; results leave
// at one per cycle while out_ch is ready, a note pair giving two results, so
// note-heavy streams are bound by the output register.
// Reset is synchronous, active low; state comes up ready for a new stream.
// in_ch stalls only when the job queue between parser and emitter is full.
// ----------------------------------------------------------------------------
module xmi_event_stream_parser #(
  parameter int TICK_BITS   = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  xesp_in_if.sink     in_ch,
  xesp_out_if.source  out_ch
);

  localparam int JOB_W = $bits(xesp_pkg::job_t) + TICK_BITS;

  logic                 q_push, q_pop, q_empty, q_full;
  xesp_pkg::job_t       push_job, pop_job;
  logic [TICK_BITS-1:0] push_tick, pop_tick;
  logic [JOB_W-1:0]     pop_data;

  // parser
  xesp_front #(.TICK_BITS(TICK_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job),
    .q_tick (push_tick)
  );

  // job queue
  xesp_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_job, push_tick}),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign {pop_job, pop_tick} = pop_data;

  // emitter
  xesp_back #(.TICK_BITS(TICK_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_job   (pop_job),
    .q_tick  (pop_tick),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // parser never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("job pushed into full queue");

  // only the note-on of a pair is not last of its run
  a_mid_is_note_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last_of_run |->
      out_ch.event_kind == xesp_pkg::EV_NOTE_ON)
    else $error("non-last result is not a note-on");

  // a taken note-on of a pair is followed by its note-off on the same channel
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last_of_run |=>
      out_ch.valid && out_ch.last_of_run &&
      out_ch.event_kind == xesp_pkg::EV_NOTE_OFF &&
      out_ch.channel_number == $past(out_ch.channel_number) &&
      out_ch.first_data == $past(out_ch.first_data))
    else $error("note-off does not follow its note-on");

endmodule

@@ sv/xesp_front.sv @@
// ----------------------------------------------------------------------------
// xesp_front: byte parser
// Accepts one byte per cycle while the queue is not full, tracks the parse
// phase, tick and VLQs, pushes one job per result-producing byte to it.
// ----------------------------------------------------------------------------
module xesp_front #(
  parameter int TICK_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  xesp_in_if.sink               in_ch,
  input  logic                  q_full,
  output logic                  q_push,
  output xesp_pkg::job_t        q_job,
  output logic [TICK_BITS-1:0]  q_tick
);

  localparam int VB = xesp_pkg::VLQ_BITS;

  xesp_pkg::phase_t       phase_r, phase_nxt;
  logic [TICK_BITS-1:0]   tick_r, tick_nxt;
  logic [7:0]             status_r, status_nxt;
  logic [7:0]             first_r, first_nxt;
  logic [7:0]             second_r, second_nxt;
  logic [VB-1:0]          vlq_r, vlq_nxt;
  logic [2:0]             cnt_r, cnt_nxt;
  logic [VB-1:0]          skip_r, skip_nxt;
  logic                   meta_end_r, meta_end_nxt;

  logic          acc;
  logic [7:0]    b;
  logic          fin;
  logic [VB-1:0] vlq_shift;
  logic [2:0]    cnt_inc;
  logic          vlq_done;
  logic [VB-1:0] skip_dec;

  // a job may be pushed on any accepted byte, so hold off while full
  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && !q_full;
  assign b           = in_ch.byte_value;
  assign fin         = in_ch.final_byte;

  assign vlq_shift = {vlq_r[VB-8:0], b[6:0]};
  assign cnt_inc   = cnt_r + 3'd1;
  assign vlq_done  = !b[7] || (cnt_inc >= xesp_pkg::VLQ_MAX_BYTES) || fin;
  assign skip_dec  = skip_r - VB'(1);
  assign q_tick    = tick_r;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= xesp_pkg::PH_IDLE;
      tick_r     <= '0;
      status_r   <= '0;
      first_r    <= '0;
      second_r   <= '0;
      vlq_r      <= '0;
      cnt_r      <= '0;
      skip_r     <= '0;
      meta_end_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      status_r   <= status_nxt;
      first_r    <= first_nxt;
      second_r   <= second_nxt;
      vlq_r      <= vlq_nxt;
      cnt_r      <= cnt_nxt;
      skip_r     <= skip_nxt;
      meta_end_r <= meta_end_nxt;
    end
  end

  // next state and job generation
  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    status_nxt   = status_r;
    first_nxt    = first_r;
    second_nxt   = second_r;
    vlq_nxt      = vlq_r;
    cnt_nxt      = cnt_r;
    skip_nxt     = skip_r;
    meta_end_nxt = meta_end_r;
    q_push       = 1'b0;
    q_job        = '0;
    q_job.channel = status_r[3:0];

    if (acc) begin
      case (phase_r)
        xesp_pkg::PH_IDLE: begin
          if (!b[7]) begin
            tick_nxt = tick_r + TICK_BITS'(b);
            if (b != xesp_pkg::INTERVAL_MORE) phase_nxt = xesp_pkg::PH_STATUS_DUE;
          end else begin
            status_nxt = b;
            vlq_nxt    = '0;
            cnt_nxt    = '0;
            phase_nxt  = xesp_pkg::status_phase(b);
          end
        end
        xesp_pkg::PH_STATUS_DUE: begin
          if (!b[7]) begin
            phase_nxt = xesp_pkg::PH_HALT;
          end else begin
            status_nxt = b;
            vlq_nxt    = '0;
            cnt_nxt    = '0;
            phase_nxt  = xesp_pkg::status_phase(b);
          end
        end
        xesp_pkg::PH_META_TYPE: begin
          meta_end_nxt = (b == xesp_pkg::META_END);
          vlq_nxt      = '0;
          cnt_nxt      = '0;
          phase_nxt    = xesp_pkg::PH_META_LEN;
          // stream ends after the type: zero length
          if (fin && meta_end_nxt) begin
            q_push        = 1'b1;
            q_job.kind    = xesp_pkg::EV_END_TRACK;
            q_job.channel = '0;
          end
        end
        xesp_pkg::PH_META_LEN: begin
          vlq_nxt = vlq_shift;
          cnt_nxt = cnt_inc;
          if (vlq_done) begin
            if (meta_end_r) begin
              q_push        = 1'b1;
              q_job.kind    = xesp_pkg::EV_END_TRACK;
              q_job.channel = '0;
            end
            skip_nxt  = vlq_shift;
            phase_nxt = (vlq_shift == '0) ? xesp_pkg::PH_IDLE : xesp_pkg::PH_SKIP;
          end
        end
        xesp_pkg::PH_SYSEX_LEN: begin
          vlq_nxt = vlq_shift;
          cnt_nxt = cnt_inc;
          if (vlq_done) begin
            skip_nxt  = vlq_shift;
            phase_nxt = (vlq_shift == '0) ? xesp_pkg::PH_IDLE : xesp_pkg::PH_SKIP;
          end
        end
        xesp_pkg::PH_NOTE_KEY: begin
          first_nxt = b;
          phase_nxt = xesp_pkg::PH_NOTE_VEL;
        end
        xesp_pkg::PH_NOTE_VEL: begin
          second_nxt = b;
          vlq_nxt    = '0;
          cnt_nxt    = '0;
          phase_nxt  = xesp_pkg::PH_NOTE_DUR;
          // stream ends before the duration: zero duration
          if (fin) begin
            q_push       = 1'b1;
            q_job.pair   = 1'b1;
            q_job.kind   = xesp_pkg::EV_NOTE_ON;
            q_job.first  = first_r;
            q_job.second = b;
          end
        end
        xesp_pkg::PH_NOTE_DUR: begin
          vlq_nxt = vlq_shift;
          cnt_nxt = cnt_inc;
          if (vlq_done) begin
            q_push       = 1'b1;
            q_job.pair   = 1'b1;
            q_job.kind   = xesp_pkg::EV_NOTE_ON;
            q_job.first  = first_r;
            q_job.second = second_r;
            q_job.dur    = vlq_shift;
            phase_nxt    = xesp_pkg::PH_IDLE;
          end
        end
        xesp_pkg::PH_DATA1: begin
          first_nxt = b;
          if (status_r[7:4] == xesp_pkg::HI_PROGRAM ||
              status_r[7:4] == xesp_pkg::HI_CHAN_PRESS) begin
            q_push      = 1'b1;
            q_job.kind  = xesp_pkg::kind_of(status_r[7:4]);
            q_job.first = b;
            phase_nxt   = xesp_pkg::PH_IDLE;
          end else begin
            phase_nxt = xesp_pkg::PH_DATA2;
          end
        end
        xesp_pkg::PH_DATA2: begin
          second_nxt   = b;
          q_push       = 1'b1;
          q_job.kind   = xesp_pkg::kind_of(status_r[7:4]);
          q_job.first  = first_r;
          q_job.second = b;
          phase_nxt    = xesp_pkg::PH_IDLE;
        end
        xesp_pkg::PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) phase_nxt = xesp_pkg::PH_IDLE;
        end
        default: begin
          phase_nxt = xesp_pkg::PH_HALT;
        end
      endcase

      // last byte of the chunk: back to reset values for the next stream
      if (fin) begin
        phase_nxt    = xesp_pkg::PH_IDLE;
        tick_nxt     = '0;
        status_nxt   = '0;
        first_nxt    = '0;
        second_nxt   = '0;
        vlq_nxt      = '0;
        cnt_nxt      = '0;
        skip_nxt     = '0;
        meta_end_nxt = 1'b0;
      end
    end
  end

endmodule

@@ sv/xesp_queue.sv @@
// ----------------------------------------------------------------------------
// xesp_queue: job queue between parser and emitter
// Small register FIFO, one push and one pop per cycle, if not full/empty.
// ----------------------------------------------------------------------------
module xesp_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // pointer and count update, wrapping at DEPTH
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

@@ sv/xesp_back.sv @@
// ----------------------------------------------------------------------------
// xesp_back: event emitter
// Expands each queued job into one or two results and holds them in the
// output register; a note pair gives the note-on, then the note-off at
// tick plus duration.
// ----------------------------------------------------------------------------
module xesp_back #(
  parameter int TICK_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  xesp_pkg::job_t        q_job,
  input  logic [TICK_BITS-1:0]  q_tick,
  output logic                  q_pop,
  xesp_out_if.source            out_ch
);

  logic                 out_valid_r, out_valid_nxt;
  logic                 half_r, half_nxt;
  logic [2:0]           kind_r, kind_nxt;
  logic [3:0]           chan_r, chan_nxt;
  logic [7:0]           first_r, first_nxt;
  logic [7:0]           second_r, second_nxt;
  logic [31:0]          tick_r, tick_nxt;
  logic                 last_r, last_nxt;
  logic                 load;
  logic [TICK_BITS-1:0] off_tick;

  assign load     = !out_valid_r || out_ch.ready;
  assign off_tick = q_tick + TICK_BITS'(q_job.dur);

  assign out_ch.valid          = out_valid_r;
  assign out_ch.event_kind     = kind_r;
  assign out_ch.channel_number = chan_r;
  assign out_ch.first_data     = first_r;
  assign out_ch.second_data    = second_r;
  assign out_ch.event_tick     = tick_r;
  assign out_ch.last_of_run    = last_r;

  // result selection
  always_comb begin
    out_valid_nxt = out_valid_r;
    half_nxt      = half_r;
    kind_nxt      = kind_r;
    chan_nxt      = chan_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    tick_nxt      = tick_r;
    last_nxt      = last_r;
    q_pop         = 1'b0;

    if (load) begin
      out_valid_nxt = !q_empty;
      if (!q_empty) begin
        chan_nxt  = q_job.channel;
        first_nxt = q_job.first;
        if (q_job.pair && half_r) begin
          // second half of a note pair
          kind_nxt   = xesp_pkg::EV_NOTE_OFF;
          second_nxt = '0;
          tick_nxt   = 32'(off_tick);
          last_nxt   = 1'b1;
          half_nxt   = 1'b0;
          q_pop      = 1'b1;
        end else begin
          kind_nxt   = q_job.kind;
          second_nxt = q_job.second;
          tick_nxt   = 32'(q_tick);
          last_nxt   = !q_job.pair;
          half_nxt   = q_job.pair;
          q_pop      = !q_job.pair;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      half_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      half_r      <= half_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    chan_r   <= chan_nxt;
    first_r  <= first_nxt;
    second_r <= second_nxt;
    tick_r   <= tick_nxt;
    last_r   <= last_nxt;
  end

endmodule
